// File: rtl/bmt_pkg.sv
// shared types and constants of the bit matrix transpose buffer
package bmt_pkg;

    localparam int MAX_ROWS   = 256;
    localparam int MAX_COLS   = 256;
    localparam int ROW_BYTES  = MAX_COLS / 8;
    localparam int BANKS      = 8;
    localparam int BANK_DEPTH = (MAX_ROWS / BANKS) * ROW_BYTES;
    localparam int ADDR_W     = $clog2(BANK_DEPTH);
    localparam int WIN_W      = 9;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_HIGH = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic mem_wr;
        logic rd_capture;
    } cmd_t;

    typedef struct packed {
        logic op_read;
    } status_t;

endpackage

// File: rtl/bit_matrix_transpose_buffer_top.sv
// top level of the bit matrix transpose buffer
// A write item stores one byte of a 256 x 256 packed bit matrix; in_ready stays
// high for back-to-back writes. A read item returns one byte of the transposed
// matrix: the eight row banks are read together at the accept edge and the
// result is shown in the next cycle from the registered bank reads. Reads of
// blocks outside the rounded window return zero with out_of_window set. The
// store is not cleared at reset.
// Configuration writes are always accepted (cfg_ready tied high).
module bit_matrix_transpose_buffer_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            operation,
    input  logic [7:0]                      src_row,
    input  logic [4:0]                      src_byte_col,
    input  logic [7:0]                      write_byte,
    input  logic [7:0]                      dst_row,
    input  logic [4:0]                      dst_byte_col,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      read_byte,
    output logic                            out_of_window,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bmt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmt_pkg::WIN_W-1:0]       cfg_data
);

    bmt_pkg::cmd_t    cmd;
    bmt_pkg::status_t status;

    assign cfg_ready = 1'b1;

    bmt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    bmt_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .operation     (operation),
        .src_row       (src_row),
        .src_byte_col  (src_byte_col),
        .write_byte    (write_byte),
        .dst_row       (dst_row),
        .dst_byte_col  (dst_byte_col),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .read_byte     (read_byte),
        .out_of_window (out_of_window)
    );

endmodule

// File: rtl/bmt_ctrl.sv
// controller state machine of the bit matrix transpose buffer
module bmt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_ready,
    input  bmt_pkg::status_t  status,
    output logic              in_ready,
    output logic              out_valid,
    output bmt_pkg::cmd_t     cmd
);

    bmt_pkg::state_t state_reg;
    bmt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bmt_pkg::ST_IDLE:
            begin
                if (in_valid && status.op_read)
                begin
                    state_next = bmt_pkg::ST_RESP;
                end
            end
            bmt_pkg::ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = bmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bmt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd.mem_wr     = 1'b0;
        cmd.rd_capture = 1'b0;
        unique case (state_reg)
            bmt_pkg::ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.mem_wr     = in_valid && !status.op_read;
                cmd.rd_capture = in_valid && status.op_read;
            end
            bmt_pkg::ST_RESP:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/bmt_datapath.sv
// datapath: window registers, eight row-banked byte memories and bit gather
module bmt_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  bmt_pkg::cmd_t                   cmd,
    output bmt_pkg::status_t                status,
    input  logic                            operation,
    input  logic [7:0]                      src_row,
    input  logic [4:0]                      src_byte_col,
    input  logic [7:0]                      write_byte,
    input  logic [7:0]                      dst_row,
    input  logic [4:0]                      dst_byte_col,
    input  logic                            cfg_wr,
    input  logic [bmt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmt_pkg::WIN_W-1:0]       cfg_data,
    output logic [7:0]                      read_byte,
    output logic                            out_of_window
);

    logic [bmt_pkg::WIN_W-1:0] row_low_reg;
    logic [bmt_pkg::WIN_W-1:0] row_high_reg;
    logic [bmt_pkg::WIN_W-1:0] col_low_reg;
    logic [bmt_pkg::WIN_W-1:0] col_high_reg;

    logic [7:0] mem_reg [bmt_pkg::BANKS][bmt_pkg::BANK_DEPTH];
    logic [7:0] rd_data_reg [bmt_pkg::BANKS];
    logic [2:0] bit_sel_reg;
    logic       oow_reg;

    logic [bmt_pkg::ADDR_W-1:0] wr_addr;
    logic [bmt_pkg::ADDR_W-1:0] rd_addr;
    logic [2:0]                 wr_bank;
    logic [7:0]                 row_base;
    logic [7:0]                 col_base;
    logic                       row_in;
    logic                       col_in;
    logic [7:0]                 gathered;

    assign status.op_read = (operation == bmt_pkg::OP_READ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_low_reg  <= 9'd0;
            row_high_reg <= 9'd256;
            col_low_reg  <= 9'd0;
            col_high_reg <= 9'd256;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                bmt_pkg::CFG_ROW_LOW:  row_low_reg  <= cfg_data;
                bmt_pkg::CFG_ROW_HIGH: row_high_reg <= cfg_data;
                bmt_pkg::CFG_COL_LOW:  col_low_reg  <= cfg_data;
                bmt_pkg::CFG_COL_HIGH: col_high_reg <= cfg_data;
                default:               row_low_reg  <= row_low_reg;
            endcase
        end
    end

    function automatic logic in_window(input logic [7:0] base,
                                       input logic [bmt_pkg::WIN_W-1:0] lo,
                                       input logic [bmt_pkg::WIN_W-1:0] hi);
        logic [9:0] lo_down;
        logic [9:0] hi_up;
        logic [9:0] base_ext;
        lo_down  = {1'b0, lo[8:3], 3'b000};
        hi_up    = ({1'b0, hi} + 10'd7) & ~10'd7;
        base_ext = {2'b00, base};
        return (base_ext >= lo_down) && (base_ext < hi_up);
    endfunction

    // bank is the row within its group of eight, address is group and byte column
    assign wr_bank  = src_row[2:0];
    assign wr_addr  = {src_row[7:3], src_byte_col};
    assign rd_addr  = {dst_byte_col, dst_row[7:3]};
    assign row_base = {dst_byte_col, 3'b000};
    assign col_base = {dst_row[7:3], 3'b000};
    assign row_in   = in_window(row_base, row_low_reg, row_high_reg);
    assign col_in   = in_window(col_base, col_low_reg, col_high_reg);

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < bmt_pkg::BANKS; b++)
        begin
            if (cmd.mem_wr && (wr_bank == 3'(b)))
            begin
                mem_reg[b][wr_addr] <= write_byte;
            end
            if (cmd.rd_capture)
            begin
                rd_data_reg[b] <= mem_reg[b][rd_addr];
            end
        end
        if (cmd.rd_capture)
        begin
            bit_sel_reg <= 3'd7 - dst_row[2:0];
            oow_reg     <= !(row_in && col_in);
        end
    end

    // source row 8g+k lands in bit 7-k
    always_comb
    begin
        for (int k = 0; k < bmt_pkg::BANKS; k++)
        begin
            gathered[7-k] = rd_data_reg[k][bit_sel_reg];
        end
    end

    assign read_byte     = oow_reg ? 8'd0 : gathered;
    assign out_of_window = oow_reg;

endmodule

// File: rtl/bmt_checker.sv
// port-level checker of the bit matrix transpose buffer and its bind
module bmt_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       operation,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_byte,
    input logic       out_of_window
);

    // a waiting result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_byte) && $stable(out_of_window))
    else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_window |-> read_byte == 8'd0)
    else $error("out-of-window item carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation |=> out_valid)
    else $error("read item gave no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !operation |=> !out_valid)
    else $error("write item gave a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
    else $error("item accepted while a result waits");

endmodule

bind bit_matrix_transpose_buffer_top bmt_checker u_bmt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_byte     (read_byte),
    .out_of_window (out_of_window)
);
